>>> hw/rtl/mcsf_pkg.sv
// shared types, constants and window tables for the motor command safety filter
package mcsf_pkg;

   localparam int MOTORS_DEF = 8;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 4;
   localparam int POS_W   = 20;
   localparam int SPD_W   = 8;
   localparam int FORCE_W = 16;
   localparam int TIME_W  = 32;
   localparam int RATE_W  = 16;
   localparam int PROD_W  = RATE_W + TIME_W;
   localparam int STEP_W  = POS_W + 1;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // request tdata field positions
   localparam int REQ_ID_LSB    = 0;
   localparam int REQ_POS_LSB   = 4;
   localparam int REQ_SPD_LSB   = 24;
   localparam int REQ_FORCE_LSB = 32;
   localparam int REQ_NOW_LSB   = 48;

   // response tdata field positions
   localparam int RSP_ACC_BIT   = 0;
   localparam int RSP_POS_LSB   = 1;
   localparam int RSP_SPD_LSB   = 21;
   localparam int RSP_FAULT_BIT = 29;

   localparam logic [STEP_W-1:0] RATE_SAT = STEP_W'(1 << POS_W);

   localparam logic [FORCE_W-1:0] SOFT_FORCE_RST  = 16'd1200;
   localparam logic [SPD_W-1:0]   REDUCED_SPD_RST = 8'd25;
   localparam logic [FORCE_W-1:0] HAND_HARD_RST   = 16'd1600;
   localparam logic [FORCE_W-1:0] WRIST_HARD_RST  = 16'd2000;
   localparam logic [RATE_W-1:0]  RATE_RST        = 16'd206;

   typedef enum logic [CMD_W-1:0] {
      CMD_POSITION = 2'd0,
      CMD_FEEDBACK = 2'd1,
      CMD_STOP     = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      REG_SOFT_FORCE  = 3'd0,
      REG_REDUCED_SPD = 3'd1,
      REG_HAND_HARD   = 3'd2,
      REG_WRIST_HARD  = 3'd3,
      REG_RATE        = 3'd4
   } reg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [TIME_W-1:0]       last_ms;
      logic [FORCE_W-1:0]      force_val;
   } entry_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [ID_W-1:0]         id;
      logic                    id_ok;
      logic signed [POS_W-1:0] pos;
      logic [SPD_W-1:0]        speed;
      logic [FORCE_W-1:0]      force_val;
      logic [TIME_W-1:0]       now_ms;
   } item_type;

   function automatic logic signed [POS_W-1:0] win_lo(input logic [ID_W-1:0] id);
      logic signed [POS_W-1:0] v;
      case (id)
         4'd0: v = -20'sd11438;
         4'd1, 4'd2, 4'd3, 4'd4: v = 20'sd0;
         4'd5, 4'd6: v = -20'sd34315;
         4'd7: v = -20'sd5719;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [POS_W-1:0] win_hi(input logic [ID_W-1:0] id);
      logic signed [POS_W-1:0] v;
      case (id)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4: v = 20'sd102944;
         4'd5, 4'd6: v = 20'sd34315;
         4'd7: v = 20'sd17157;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

   function automatic logic is_wrist(input logic [ID_W-1:0] id);
      return (id == 4'd5) || (id == 4'd6);
   endfunction

endpackage

>>> hw/rtl/motor_command_safety_filter.sv
// per-motor position clamp, slew limiter and force fault guard
// One transaction per clock is accepted while the response side is ready; each request gives
// one response, registered through stage 1, stage 2 and the response register. Per-motor state
// (last position, last command tick, latest force) sits in a small synchronous memory read at
// request acceptance and written back from the commit stage, with forwarding from that stage
// so back-to-back requests to one motor see each other's updates. The 16 x 32 rate multiply
// sits in stage 1, ahead of the slew compare in stage 2. While a response waits, the two stages
// behind it keep their transactions, so up to three are held before the request side stalls.
module motor_command_safety_filter #(
   parameter int MOTORS = mcsf_pkg::MOTORS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // motor_id[3:0], target_position[23:4], speed_request[31:24],
   // measured_force[47:32], now_ms[79:48]
   input  logic [mcsf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[1:0]
   input  logic [mcsf_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // accepted[0], safe_position[20:1], safe_speed[28:21], fault_active[29], zero[31:30]
   output logic [mcsf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mcsf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mcsf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mcsf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import mcsf_pkg::*;

   localparam int ADDR_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int LIM_W  = ID_W + 1;
   localparam logic [LIM_W-1:0] MOTORS_LIM = LIM_W'(MOTORS);

   // configuration registers
   logic [FORCE_W-1:0] soft_ff, hand_ff, wrist_ff;
   logic [SPD_W-1:0]   reduced_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic               csr_we;
   reg_type            csr_sel;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff    <= SOFT_FORCE_RST;
         reduced_ff <= REDUCED_SPD_RST;
         hand_ff    <= HAND_HARD_RST;
         wrist_ff   <= WRIST_HARD_RST;
         rate_ff    <= RATE_RST;
      end else if (csr_we) begin
         case (csr_sel)
            REG_SOFT_FORCE:  soft_ff    <= csr_pwdata[FORCE_W-1:0];
            REG_REDUCED_SPD: reduced_ff <= csr_pwdata[SPD_W-1:0];
            REG_HAND_HARD:   hand_ff    <= csr_pwdata[FORCE_W-1:0];
            REG_WRIST_HARD:  wrist_ff   <= csr_pwdata[FORCE_W-1:0];
            REG_RATE:        rate_ff    <= csr_pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_SOFT_FORCE:  csr_prdata = CSR_DATA_W'(soft_ff);
         REG_REDUCED_SPD: csr_prdata = CSR_DATA_W'(reduced_ff);
         REG_HAND_HARD:   csr_prdata = CSR_DATA_W'(hand_ff);
         REG_WRIST_HARD:  csr_prdata = CSR_DATA_W'(wrist_ff);
         REG_RATE:        csr_prdata = CSR_DATA_W'(rate_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_free, s2_free, s2_adv, s1_free, s1_adv, in_acc;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_adv     = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign in_acc     = req_tvalid && req_tready;

   // request unpack
   item_type          in_item;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      in_item.cmd       = req_tuser[CMD_W-1:0];
      in_item.id        = req_tdata[REQ_ID_LSB +: ID_W];
      in_item.id_ok     = {1'b0, in_item.id} < MOTORS_LIM;
      in_item.pos       = signed'(req_tdata[REQ_POS_LSB +: POS_W]);
      in_item.speed     = req_tdata[REQ_SPD_LSB +: SPD_W];
      in_item.force_val = req_tdata[REQ_FORCE_LSB +: FORCE_W];
      in_item.now_ms    = req_tdata[REQ_NOW_LSB +: TIME_W];
   end

   assign rd_addr = in_item.id_ok ? in_item.id[ADDR_W-1:0] : '0;

   // per-motor state memory
   entry_type         mem [MOTORS];
   logic [MOTORS-1:0] mem_vld_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         s1_rd_ff;
   item_type          s1_item_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (wr_en) begin
         mem_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            s1_rd_ff <= wr_data;
         end else if (mem_vld_ff[rd_addr]) begin
            s1_rd_ff <= mem[rd_addr];
         end else begin
            s1_rd_ff <= '0;
         end
         s1_item_ff <= in_item;
      end
   end

   // stage 1: forward, clamp, elapsed time and rate product
   entry_type               s1_old;
   logic signed [POS_W-1:0] s1_lo, s1_hi, s1_clamp;
   logic [TIME_W-1:0]       s1_elapsed;
   logic [PROD_W-1:0]       s1_prod;
   logic [FORCE_W-1:0]      s1_hard;

   always_comb begin
      if (wr_en && (wr_addr == s1_item_ff.id[ADDR_W-1:0])) begin
         s1_old = wr_data;
      end else begin
         s1_old = s1_rd_ff;
      end
      s1_lo = win_lo(s1_item_ff.id);
      s1_hi = win_hi(s1_item_ff.id);
      if (s1_item_ff.pos < s1_lo) begin
         s1_clamp = s1_lo;
      end else if (s1_item_ff.pos > s1_hi) begin
         s1_clamp = s1_hi;
      end else begin
         s1_clamp = s1_item_ff.pos;
      end
      s1_elapsed = s1_item_ff.now_ms - s1_old.last_ms;
      s1_prod    = PROD_W'(rate_ff) * PROD_W'(s1_elapsed);
      s1_hard    = is_wrist(s1_item_ff.id) ? wrist_ff : hand_ff;
   end

   item_type                s2_item_ff;
   entry_type               s2_old_ff;
   logic signed [POS_W-1:0] s2_clamp_ff;
   logic [PROD_W-1:0]       s2_prod_ff;
   logic                    s2_hard_ff, s2_soft_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_item_ff  <= s1_item_ff;
         s2_old_ff   <= s1_old;
         s2_clamp_ff <= s1_clamp;
         s2_prod_ff  <= s1_prod;
         s2_hard_ff  <= s1_old.force_val >= s1_hard;
         s2_soft_ff  <= s1_old.force_val >= soft_ff;
      end
   end

   // stage 2: slew limit, fault decision, write back
   logic                    fault_ff, fault_in;
   logic [STEP_W-1:0]       s2_step;
   logic signed [22:0]      s2_last, s2_delta, s2_step_s, s2_up, s2_dn;
   logic signed [POS_W-1:0] s2_lim;
   logic                    s2_go, s2_fb, s2_acc;
   logic [SPD_W-1:0]        s2_spd;
   logic [RSP_DATA_W-1:0]   s2_rsp;

   always_comb begin
      s2_step   = (|s2_prod_ff[PROD_W-1:POS_W]) ? RATE_SAT : {1'b0, s2_prod_ff[POS_W-1:0]};
      s2_last   = 23'(s2_old_ff.pos);
      s2_delta  = 23'(s2_clamp_ff) - s2_last;
      s2_step_s = signed'({2'b00, s2_step});
      s2_up     = s2_last + s2_step_s;
      s2_dn     = s2_last - s2_step_s;
      if (s2_delta > s2_step_s) begin
         s2_lim = s2_up[POS_W-1:0];
      end else if (s2_delta < -s2_step_s) begin
         s2_lim = s2_dn[POS_W-1:0];
      end else begin
         s2_lim = s2_clamp_ff;
      end

      s2_go  = (s2_item_ff.cmd == CMD_POSITION) && s2_item_ff.id_ok && !fault_ff;
      s2_fb  = (s2_item_ff.cmd == CMD_FEEDBACK) && s2_item_ff.id_ok;
      s2_acc = s2_go && !s2_hard_ff;
      s2_spd = (s2_soft_ff && (s2_item_ff.speed > reduced_ff)) ? reduced_ff
                                                               : s2_item_ff.speed;

      wr_en   = s2_adv && (s2_go || s2_fb);
      wr_addr = s2_item_ff.id[ADDR_W-1:0];
      wr_data = s2_old_ff;
      if (s2_go) begin
         wr_data.last_ms = s2_item_ff.now_ms;
         wr_data.pos     = s2_lim;
      end else if (s2_fb) begin
         wr_data.force_val = s2_item_ff.force_val;
         wr_data.pos       = s2_item_ff.pos;
      end

      fault_in = fault_ff || (s2_adv && ((s2_go && s2_hard_ff) ||
                                          (s2_item_ff.cmd == CMD_STOP)));

      s2_rsp = '0;
      s2_rsp[RSP_ACC_BIT]             = s2_acc;
      s2_rsp[RSP_POS_LSB +: POS_W]    = s2_acc ? s2_lim : '0;
      s2_rsp[RSP_SPD_LSB +: SPD_W]    = s2_acc ? s2_spd : '0;
      s2_rsp[RSP_FAULT_BIT]           = fault_in;
   end

   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_data_ff <= s2_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fault_ff     <= 1'b0;
      end else begin
         fault_ff <= fault_in;
         if (s1_free) begin
            s1_valid_ff <= in_acc;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_adv;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_adv;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/mcsf_checker.sv
// port-level checks for the motor command safety filter, with its bind
module mcsf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mcsf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mcsf_pkg::*;

   logic seen_fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fault_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[RSP_FAULT_BIT]) begin
         seen_fault_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_ACC_BIT] |->
         (rsp_tdata[RSP_POS_LSB +: POS_W] == '0) && (rsp_tdata[RSP_SPD_LSB +: SPD_W] == '0))
      else $error("rejected transaction carries a position or speed");

   a_accept_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_ACC_BIT] |-> !rsp_tdata[RSP_FAULT_BIT])
      else $error("command accepted with fault latched");

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_fault_ff && rsp_tvalid |-> rsp_tdata[RSP_FAULT_BIT])
      else $error("fault latch cleared without reset");

endmodule

bind motor_command_safety_filter mcsf_checker u_mcsf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
